[rtl/core/dsw_pkg.sv]
package dsw_pkg;

    localparam int KHZ_W  = 17;
    localparam int WORD_W = 32;
    localparam int STEP_W = 7;
    localparam int PROD_W = KHZ_W + WORD_W;

    localparam logic [WORD_W-1:0] SCALE_RESET = 32'd2345624806;
    localparam logic [WORD_W-1:0] WORD_MAX    = {WORD_W{1'b1}};

    // Command kinds.
    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // The quotient is resolved a few bits per divider stage.
    localparam int DIV_BITS_PER_STG = 4;
    localparam int DIV_STAGES       = WORD_W / DIV_BITS_PER_STG;

    // One command on its way through the pipeline. The num field holds the
    // word span before the divider and the per-step delta after it.
    typedef struct packed {
        logic              vld;
        logic              sweep;
        logic [STEP_W-1:0] steps;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] num;
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [STEP_W-1:0] rem;
    } t_div_stg;

    // Restoring division, several quotient bits. The dividend shifts out at
    // the top while quotient bits shift in at the bottom of the same word.
    function automatic logic [STEP_W+WORD_W-1:0] div_bits(
        input logic [STEP_W-1:0] rem,
        input logic [WORD_W-1:0] q,
        input logic [STEP_W-1:0] dvs
    );
        logic [STEP_W:0]   t;
        logic [STEP_W-1:0] r;
        logic [WORD_W-1:0] qq;
        r  = rem;
        qq = q;
        for (int k = 0; k < DIV_BITS_PER_STG; k++) begin
            t  = {r, qq[WORD_W-1]};
            qq = {qq[WORD_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                r     = STEP_W'(t - {1'b0, dvs});
                qq[0] = 1'b1;
            end else begin
                r = t[STEP_W-1:0];
            end
        end
        return {r, qq};
    endfunction

endpackage

[rtl/core/dds_sweep_word_generator.sv]
// Channel    Direction  Handshake            Payload
// command    in         i_valid / o_ready    i_func, i_start_khz, i_end_khz, i_step_count
// word       out        o_valid / i_ready    o_tuning_word, o_in_sweep, o_last
// scale cfg  in         i_cfg_we             i_cfg_data
//
// A command passes through the pipeline (two multiply/saturate stages, one subtract
// stage, eight divider stages) and is then loaded into the word emitter, which
// streams one word per cycle while the word channel is not stalled. o_ready is low
// until the last word of a sweep is issued, and the pipeline freezes meanwhile.
// Reset is synchronous and active low; it clears the valid bits and restores
// the scale register. Stalls on the word channel hold the emitter, and while it
// still has words to send they hold every stage in place as well.
module dds_sweep_word_generator
    import dsw_pkg::*;
#(
    parameter int MAX_STEPS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [KHZ_W-1:0]  i_start_khz,
    input  logic [KHZ_W-1:0]  i_end_khz,
    input  logic [STEP_W-1:0] i_step_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_tuning_word,
    output logic              o_in_sweep,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_data
);

    // The kHz-to-word scale, unsigned 16.16 fixed point.
    logic [WORD_W-1:0] r_scale;

    // The whole pipeline advances only while the emitter is free to take
    // whatever reaches the divider output.
    logic w_en;
    logic w_busy;
    t_cmd w_conv_cmd;
    t_cmd w_div_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    assign w_en    = !w_busy;
    assign o_ready = w_en;

    // Converts both frequencies to words and forms the word span.
    dsw_word_conv #(
        .MAX_STEPS (MAX_STEPS)
    ) u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_valid),
        .i_func       (i_func),
        .i_start_khz  (i_start_khz),
        .i_end_khz    (i_end_khz),
        .i_step_count (i_step_count),
        .i_scale      (r_scale),
        .o_cmd        (w_conv_cmd)
    );

    // Divides the span by the step count to get the per-step delta.
    dsw_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cmd   (w_conv_cmd),
        .o_cmd   (w_div_cmd)
    );

    // Walks the sweep and drives the registered output. A sweep with no
    // steps is simply dropped here.
    dsw_emitter u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_div_cmd),
        .o_busy        (w_busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tuning_word (o_tuning_word),
        .o_in_sweep    (o_in_sweep),
        .o_last        (o_last)
    );

endmodule

[rtl/core/dsw_word_conv.sv]
module dsw_word_conv
    import dsw_pkg::*;
#(
    parameter int MAX_STEPS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_func,
    input  logic [KHZ_W-1:0]  i_start_khz,
    input  logic [KHZ_W-1:0]  i_end_khz,
    input  logic [STEP_W-1:0] i_step_count,
    input  logic [WORD_W-1:0] i_scale,
    output t_cmd              o_cmd
);

    localparam logic [STEP_W-1:0] StepsMax = STEP_W'(MAX_STEPS);

    // Stage A: the two products.
    logic              r_a_vld;
    logic              r_a_sweep;
    logic [STEP_W-1:0] r_a_steps;
    logic [PROD_W-1:0] r_a_plo;
    logic [PROD_W-1:0] r_a_phi;
    // Stage B: saturated words.
    logic              r_b_vld;
    logic              r_b_sweep;
    logic [STEP_W-1:0] r_b_steps;
    logic [WORD_W-1:0] r_b_lo;
    logic [WORD_W-1:0] r_b_hi;
    // Stage C: span.
    t_cmd              r_c;

    logic [STEP_W-1:0] n_steps;
    logic [WORD_W-1:0] n_lo;
    logic [WORD_W-1:0] n_hi;

    always_comb begin
        if (i_func == FUNC_SET) begin
            n_steps = STEP_W'(1);
        end else if (i_step_count > StepsMax) begin
            n_steps = StepsMax;
        end else begin
            n_steps = i_step_count;
        end
        n_lo = r_a_plo[PROD_W-1] ? WORD_MAX : r_a_plo[PROD_W-2:16];
        n_hi = r_a_phi[PROD_W-1] ? WORD_MAX : r_a_phi[PROD_W-2:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c.vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld   <= i_valid;
            r_b_vld   <= r_a_vld;
            r_c.vld   <= r_b_vld;
            r_a_sweep <= i_func;
            r_a_steps <= n_steps;
            r_a_plo   <= PROD_W'(i_start_khz) * PROD_W'(i_scale);
            r_a_phi   <= PROD_W'(i_end_khz) * PROD_W'(i_scale);
            r_b_sweep <= r_a_sweep;
            r_b_steps <= r_a_steps;
            r_b_lo    <= n_lo;
            r_b_hi    <= n_hi;
            r_c.sweep <= r_b_sweep;
            r_c.steps <= r_b_steps;
            r_c.lo    <= r_b_lo;
            r_c.num   <= r_b_hi - r_b_lo;
        end
    end

    assign o_cmd = r_c;

endmodule

[rtl/core/dsw_div_pipe.sv]
module dsw_div_pipe
    import dsw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_cmd i_cmd,
    output t_cmd o_cmd
);

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
        t_div_stg                 r_stg;
        t_div_stg                 w_in;
        logic [STEP_W+WORD_W-1:0] w_res;

        if (s == 0) begin : g_first
            assign w_in = {i_cmd, {STEP_W{1'b0}}};
        end else begin : g_next
            assign w_in = g_stg[s-1].r_stg;
        end

        assign w_res = div_bits(w_in.rem, w_in.cmd.num, w_in.cmd.steps);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg.cmd.vld <= 1'b0;
            end else if (i_en) begin
                r_stg.cmd.vld   <= w_in.cmd.vld;
                r_stg.cmd.sweep <= w_in.cmd.sweep;
                r_stg.cmd.steps <= w_in.cmd.steps;
                r_stg.cmd.lo    <= w_in.cmd.lo;
                r_stg.cmd.num   <= w_res[WORD_W-1:0];
                r_stg.rem       <= w_res[STEP_W+WORD_W-1:WORD_W];
            end
        end
    end

    assign o_cmd = g_stg[DIV_STAGES-1].r_stg.cmd;

endmodule

[rtl/core/dsw_emitter.sv]
module dsw_emitter
    import dsw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_tuning_word,
    output logic              o_in_sweep,
    output logic              o_last
);

    logic              r_busy;
    logic              r_sweep;
    logic [STEP_W-1:0] r_left;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_delta;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_sweep;
    logic              r_out_last;

    logic w_out_free;
    logic w_emit;
    logic w_load;

    assign w_out_free = !r_out_vld || i_ready;
    assign w_emit     = r_busy && w_out_free;
    assign w_load     = !r_busy && i_cmd.vld && (i_cmd.steps != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_emit && r_left == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sweep <= i_cmd.sweep;
            r_left  <= i_cmd.steps;
            r_word  <= i_cmd.lo;
            r_delta <= i_cmd.num;
        end else if (w_emit) begin
            r_left <= r_left - STEP_W'(1);
            r_word <= r_word + r_delta;
        end
        if (w_emit) begin
            r_out_word  <= r_word;
            r_out_sweep <= r_sweep;
            r_out_last  <= (r_left == STEP_W'(1));
        end
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_out_vld;
    assign o_tuning_word = r_out_word;
    assign o_in_sweep    = r_out_sweep;
    assign o_last        = r_out_last;

endmodule

[rtl/core/dsw_checker.sv]
module dsw_checker
    import dsw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [WORD_W-1:0] o_tuning_word,
    input logic              o_in_sweep,
    input logic              o_last
);

    // A stalled word keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tuning_word))
        else $error("stalled word changed");

    // A single-frequency word is always the final one.
    a_set_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_sweep |-> o_last)
        else $error("set word without last");

    // A sweep streams without gaps once a word is taken.
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_in_sweep)
        else $error("gap inside sweep");

    // No new command is taken while a sweep is still being delivered.
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("command accepted mid-sweep");

endmodule

bind dds_sweep_word_generator dsw_checker u_chk (.*);
